// File: sv/bmfr_pkg.sv
package bmfr_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] LONG_THRESHOLD_RST = 8'd15;
	localparam logic [5:0] MIN_FRAME_BYTES_RST = 6'd5;

	localparam logic [3:0] POS_START = 4'd0;
	localparam logic [3:0] POS_LAST_DATA = 4'd8;
	localparam logic [3:0] POS_STOP = 4'd9;
	localparam logic [3:0] POS_DONE = 4'd10;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAME_BYTES = 2'd1;

	typedef enum logic [1:0] {
		CMD_PULSE = 2'd0,
		CMD_BYTE_END = 2'd1,
		CMD_FRAME_END = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_START = 3'd1,
		ST_DATA = 3'd2,
		ST_STOP = 3'd3,
		ST_INCOMPLETE = 3'd4
	} status_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_FRAME = 1'b1
	} kind_t;

	// classified item held in the queue
	typedef struct packed {
		cmd_t cmd;
		logic is_long;
		logic is_below;
	} item_t;

	typedef struct packed {
		logic retune;
		logic checksum_ok;
		logic [5:0] frame_bytes;
		logic [7:0] data_byte;
		status_t status;
		kind_t kind;
	} result_t;

endpackage

// File: sv/bmfr_front.sv
module bmfr_front (
	input  logic s_valid,
	input  logic [1:0] command,
	input  logic [7:0] duration,
	input  logic [7:0] long_threshold,
	input  logic q_ready,
	output logic s_ready,
	output logic push,
	output bmfr_pkg::item_t item
);

	bmfr_pkg::cmd_t cmd;

	always_comb begin
		cmd = bmfr_pkg::cmd_t'(command);
		item.cmd = cmd;
		item.is_long = duration > long_threshold;
		item.is_below = duration < long_threshold;
		s_ready = q_ready;
		// the unused command code is dropped here
		push = s_valid && q_ready && (cmd != bmfr_pkg::CMD_NONE);
	end

endmodule

// File: sv/bmfr_queue.sv
module bmfr_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  bmfr_pkg::item_t push_item,
	input  logic pop,
	output logic ready,
	output logic valid,
	output bmfr_pkg::item_t head
);

	localparam int D = bmfr_pkg::QUEUE_DEPTH;
	localparam int PW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	bmfr_pkg::item_t mem_q [D];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign ready = fill_q != CW'(D);
	assign valid = fill_q != '0;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/bmfr_back.sv
module bmfr_back #(
	parameter int MAX_FRAME_BYTES = bmfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  bmfr_pkg::item_t item,
	output logic pop,
	input  logic [5:0] min_frame_bytes,
	input  logic m_ready,
	output logic m_valid,
	output bmfr_pkg::result_t result
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
	localparam int WW = (CW > 6) ? CW : 6;

	logic [3:0] bit_pos_q, bit_pos_d;
	logic pend_q, pend_d;
	logic [7:0] shift_q, shift_d;
	bmfr_pkg::status_t bstat_q, bstat_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0] xor_q, xor_d;
	logic bad_q, bad_d;
	logic out_valid_q;
	bmfr_pkg::result_t out_q;
	bmfr_pkg::result_t res;
	logic has_res;

	assign pop = q_valid && (!out_valid_q || m_ready);
	assign m_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		bit_pos_d = bit_pos_q;
		pend_d = pend_q;
		shift_d = shift_q;
		bstat_d = bstat_q;
		count_d = count_q;
		xor_d = xor_q;
		bad_d = bad_q;
		res = '0;
		has_res = 1'b0;
		unique case (item.cmd)
			bmfr_pkg::CMD_PULSE: begin
				if (bit_pos_q == bmfr_pkg::POS_START) begin
					if (item.is_long) begin
						bit_pos_d = 4'd1;
					end else begin
						bstat_d = bmfr_pkg::ST_START;
						pend_d = 1'b0;
						bit_pos_d = bmfr_pkg::POS_DONE;
					end
				end else if (bit_pos_q <= bmfr_pkg::POS_LAST_DATA) begin
					if (pend_q) begin
						pend_d = 1'b0;
						if (item.is_below) begin
							shift_d = {1'b1, shift_q[7:1]};
							bit_pos_d = bit_pos_q + 4'd1;
						end else begin
							bstat_d = bmfr_pkg::ST_DATA;
							bit_pos_d = bmfr_pkg::POS_DONE;
						end
					end else if (item.is_long) begin
						shift_d = {1'b0, shift_q[7:1]};
						bit_pos_d = bit_pos_q + 4'd1;
					end else begin
						pend_d = 1'b1;
					end
				end else if (bit_pos_q == bmfr_pkg::POS_STOP) begin
					bstat_d = item.is_long ? bmfr_pkg::ST_STOP : bmfr_pkg::ST_OK;
					pend_d = 1'b0;
					bit_pos_d = bmfr_pkg::POS_DONE;
				end
			end
			bmfr_pkg::CMD_BYTE_END: begin
				has_res = 1'b1;
				res.kind = bmfr_pkg::KIND_BYTE;
				res.status = bstat_q;
				if (bstat_q == bmfr_pkg::ST_OK) begin
					res.data_byte = shift_q;
					if (count_q < CW'(MAX_FRAME_BYTES)) begin
						count_d = count_q + 1'b1;
						xor_d = xor_q ^ shift_q;
					end
				end
				bit_pos_d = bmfr_pkg::POS_START;
				pend_d = 1'b0;
				shift_d = '0;
				bstat_d = bmfr_pkg::ST_INCOMPLETE;
			end
			bmfr_pkg::CMD_FRAME_END: begin
				has_res = 1'b1;
				res.kind = bmfr_pkg::KIND_FRAME;
				res.frame_bytes = 6'(count_q);
				if (WW'(count_q) >= WW'(min_frame_bytes)) begin
					if (xor_q == '0) begin
						res.checksum_ok = 1'b1;
						bad_d = 1'b0;
					end else if (bad_q) begin
						res.retune = 1'b1;
						bad_d = 1'b0;
					end else begin
						bad_d = 1'b1;
					end
				end
				count_d = '0;
				xor_d = '0;
				bit_pos_d = bmfr_pkg::POS_START;
				pend_d = 1'b0;
				shift_d = '0;
				bstat_d = bmfr_pkg::ST_INCOMPLETE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_pos_q <= bmfr_pkg::POS_START;
			pend_q <= 1'b0;
			shift_q <= '0;
			bstat_q <= bmfr_pkg::ST_INCOMPLETE;
			count_q <= '0;
			xor_q <= '0;
			bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				bit_pos_q <= bit_pos_d;
				pend_q <= pend_d;
				shift_q <= shift_d;
				bstat_q <= bstat_d;
				count_q <= count_d;
				xor_q <= xor_d;
				bad_q <= bad_d;
			end
			if (pop && has_res) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			out_q <= res;
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAME_BYTES))
		else $error("byte count above frame limit");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(bstat_q != bmfr_pkg::ST_INCOMPLETE) |-> (bit_pos_q == bmfr_pkg::POS_DONE))
		else $error("character status set before character finished");

	a_pend_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (bit_pos_q != bmfr_pkg::POS_START && bit_pos_q <= bmfr_pkg::POS_LAST_DATA))
		else $error("short pulse pending outside data bits");

	a_byte_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.cmd == bmfr_pkg::CMD_BYTE_END) |=>
			(bit_pos_q == bmfr_pkg::POS_START && !pend_q && out_valid_q))
		else $error("byte window end did not restart character");

endmodule

// File: sv/biphase_mark_frame_receiver_core.sv
// Biphase-mark frame receiver: takes measured pulse durations and window/frame end markers
// on the input stream (tuser = command, tdata = duration) and reports decoded bytes and
// checksum-checked frame results on the output stream. One item can be taken every clock
// cycle; an item is classified against long_threshold on entry, waits in a two-entry queue
// and is then executed by the decoder, which registers each result in an output register
// before it is offered on the output stream. Downstream stalls fill the queue and then hold
// s_axis_tready low. Configuration writes are always taken and must only be made while
// idle.
module biphase_mark_frame_receiver_core #(
	parameter int MAX_FRAME_BYTES = bmfr_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // duration[7:0]
	input  logic [1:0] s_axis_tuser,   // command[1:0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status[2:0], data_byte[10:3], frame_bytes[16:11],
	                                   // checksum_ok[17], retune[18], zero[23:19]
	output logic m_axis_tuser,         // kind[0]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bmfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] long_threshold_q;
	logic [5:0] min_frame_bytes_q;
	logic q_ready, q_valid, push, pop;
	bmfr_pkg::item_t push_item, head;
	bmfr_pkg::result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_threshold_q <= bmfr_pkg::LONG_THRESHOLD_RST;
			min_frame_bytes_q <= bmfr_pkg::MIN_FRAME_BYTES_RST;
		end else if (cfg_valid) begin
			if (cfg_index == bmfr_pkg::CFG_LONG_THRESHOLD) begin
				long_threshold_q <= cfg_data;
			end else if (cfg_index == bmfr_pkg::CFG_MIN_FRAME_BYTES) begin
				min_frame_bytes_q <= cfg_data[5:0];
			end
		end
	end

	bmfr_front u_front (
		.s_valid(s_axis_tvalid),
		.command(s_axis_tuser),
		.duration(s_axis_tdata),
		.long_threshold(long_threshold_q),
		.q_ready(q_ready),
		.s_ready(s_axis_tready),
		.push(push),
		.item(push_item)
	);

	bmfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.ready(q_ready),
		.valid(q_valid),
		.head(head)
	);

	bmfr_back #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.item(head),
		.pop(pop),
		.min_frame_bytes(min_frame_bytes_q),
		.m_ready(m_axis_tready),
		.m_valid(m_axis_tvalid),
		.result(res)
	);

	assign m_axis_tuser = res.kind;
	assign m_axis_tdata = {5'd0, res.retune, res.checksum_ok, res.frame_bytes,
		res.data_byte, res.status};

endmodule
